/* rtl/u8sd_pkg.sv */
// Shared types and constants for the UTF-8 stream decoder.
package u8sd_pkg;

    localparam int unsigned CP_W = 21;

    // Result kinds
    localparam logic [1:0] KIND_CODE  = 2'd0;
    localparam logic [1:0] KIND_ERROR = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // Byte classes found by the front end
    typedef enum logic [2:0] {
        CLS_ASCII = 3'd0,
        CLS_LEAD2 = 3'd1,
        CLS_LEAD3 = 3'd2,
        CLS_LEAD4 = 3'd3,
        CLS_CONT  = 3'd4,
        CLS_BAD   = 3'd5
    } t_cls;

    // One classified byte as it travels through the queue
    typedef struct packed {
        t_cls       cls;
        logic [6:0] bits;
        logic       last;
    } t_q_entry;

endpackage

/* rtl/u8sd_front.sv */
// Front end: accepts raw bytes and classifies them for the queue.
module u8sd_front (
    input  logic                i_in_valid,
    input  logic [7:0]          i_data_byte,
    input  logic                i_last_byte,
    input  logic                i_q_full,
    output logic                o_in_stall,
    output logic                o_push,
    output u8sd_pkg::t_q_entry  o_entry
);
    import u8sd_pkg::*;

    // Stall only when the queue has no room
    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // Sort the byte by its top bits and keep only its payload bits
    always_comb begin
        o_entry.last = i_last_byte;
        if (i_data_byte[7] == 1'b0) begin
            o_entry.cls  = CLS_ASCII;
            o_entry.bits = i_data_byte[6:0];
        end else if (i_data_byte[7:6] == 2'b10) begin
            o_entry.cls  = CLS_CONT;
            o_entry.bits = {1'b0, i_data_byte[5:0]};
        end else if (i_data_byte[7:5] == 3'b110) begin
            o_entry.cls  = CLS_LEAD2;
            o_entry.bits = {2'b00, i_data_byte[4:0]};
        end else if (i_data_byte[7:4] == 4'b1110) begin
            o_entry.cls  = CLS_LEAD3;
            o_entry.bits = {3'b000, i_data_byte[3:0]};
        end else if (i_data_byte[7:3] == 5'b11110) begin
            o_entry.cls  = CLS_LEAD4;
            o_entry.bits = {4'b0000, i_data_byte[2:0]};
        end else begin
            o_entry.cls  = CLS_BAD;
            o_entry.bits = 7'd0;
        end
    end

endmodule

/* rtl/u8sd_fifo.sv */
// Short queue of classified bytes between front and back end.
module u8sd_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  u8sd_pkg::t_q_entry  i_entry,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_valid,
    output u8sd_pkg::t_q_entry  o_entry
);
    import u8sd_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_q_entry         r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count beyond depth");

    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !i_push) |=> (r_count == $past(r_count) - 1'b1))
        else $error("pop without push did not lower the count");

endmodule

/* rtl/u8sd_back.sv */
// Back end: sequence state, code point assembly and the result register.
module u8sd_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    input  u8sd_pkg::t_q_entry         i_entry,
    output logic                       o_pop,
    input  logic                       i_out_stall,
    output logic                       o_out_valid,
    output logic [u8sd_pkg::CP_W-1:0]  o_code_point,
    output logic [1:0]                 o_kind,
    output logic                       o_end_of_string
);
    import u8sd_pkg::*;

    logic [1:0]      r_pending, n_pending;
    logic [CP_W-1:0] r_gathered, n_gathered;
    logic            r_discard, n_discard;

    logic            r_out_valid;
    logic [CP_W-1:0] r_cp;
    logic [1:0]      r_kind;
    logic            r_eos;

    logic            emit;
    logic [CP_W-1:0] res_cp;
    logic [1:0]      res_kind;
    logic [CP_W-1:0] shifted;
    logic            fault;

    // Take the next request whenever the result slot is free or draining
    assign o_pop   = i_q_valid && (!r_out_valid || !i_out_stall);
    assign shifted = {r_gathered[CP_W-7:0], i_entry.bits[5:0]};

    // Decode step for the byte at the head of the queue
    always_comb begin
        n_pending  = r_pending;
        n_gathered = r_gathered;
        n_discard  = r_discard;
        emit       = 1'b0;
        res_cp     = '0;
        res_kind   = KIND_CODE;
        fault      = 1'b0;

        if (r_discard) begin
            if (i_entry.last) begin
                emit     = 1'b1;
                res_kind = KIND_END;
            end
        end else if (r_pending == 2'd0) begin
            unique case (i_entry.cls) inside
                CLS_ASCII: begin
                    emit   = 1'b1;
                    res_cp = CP_W'(i_entry.bits);
                end
                CLS_LEAD2, CLS_LEAD3, CLS_LEAD4: begin
                    if (i_entry.last) begin
                        fault = 1'b1;
                    end else begin
                        n_gathered = CP_W'(i_entry.bits);
                        unique case (i_entry.cls)
                            CLS_LEAD2: n_pending = 2'd1;
                            CLS_LEAD3: n_pending = 2'd2;
                            default:   n_pending = 2'd3;
                        endcase
                    end
                end
                default: fault = 1'b1;
            endcase
        end else if (i_entry.cls != CLS_CONT) begin
            fault = 1'b1;
        end else begin
            n_gathered = shifted;
            n_pending  = r_pending - 2'd1;
            if (r_pending == 2'd1) begin
                emit       = 1'b1;
                res_cp     = shifted;
                n_gathered = '0;
            end else if (i_entry.last) begin
                fault = 1'b1;
            end
        end

        // Error: one result, then drop bytes until the string ends
        if (fault) begin
            emit       = 1'b1;
            res_cp     = '0;
            res_kind   = KIND_ERROR;
            n_pending  = 2'd0;
            n_gathered = '0;
            n_discard  = !i_entry.last;
        end else if (i_entry.last) begin
            n_pending  = 2'd0;
            n_gathered = '0;
            n_discard  = 1'b0;
        end
    end

    // Sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending  <= '0;
            r_gathered <= '0;
            r_discard  <= 1'b0;
        end else if (o_pop) begin
            r_pending  <= n_pending;
            r_gathered <= n_gathered;
            r_discard  <= n_discard;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= emit;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_cp   <= res_cp;
            r_kind <= res_kind;
            r_eos  <= i_entry.last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_code_point    = r_cp;
    assign o_kind          = r_kind;
    assign o_end_of_string = r_eos;

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_entry.last) |=> (r_pending == 2'd0 && !r_discard && r_gathered == '0))
        else $error("state not cleared after last byte");

    a_discard_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_discard |-> (r_pending == 2'd0))
        else $error("discarding while bytes are pending");

    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_entry.last) |=> (r_out_valid && r_eos))
        else $error("last byte gave no end-of-string result");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_kind == KIND_CODE || r_kind == KIND_ERROR || r_kind == KIND_END))
        else $error("illegal result kind");

endmodule

/* rtl/utf8_stream_decoder_core.sv */
// Top level of the UTF-8 stream decoder: front end, byte queue, back end.
//
//  Channel | Direction | Handshake                | Payload
//  --------+-----------+--------------------------+-------------------------------------
//  input   | in        | i_in_valid / o_in_stall  | i_data_byte, i_last_byte
//  output  | out       | o_out_valid / i_out_stall| o_code_point, o_kind, o_end_of_string
//
// One byte per cycle sustained while o_in_stall stays low; a taken byte is stored in the queue, and its
// result is offered from the result register. The queue (QUEUE_DEPTH entries) absorbs output stalls;
// o_in_stall rises when it is full. Bytes that give no result still pass the queue and the back end.
// Reset is synchronous and active low; it empties the queue and clears the decode state.
module utf8_stream_decoder_core #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [7:0]                 i_data_byte,
    input  logic                       i_last_byte,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [u8sd_pkg::CP_W-1:0]  o_code_point,
    output logic [1:0]                 o_kind,
    output logic                       o_end_of_string
);
    import u8sd_pkg::*;

    t_q_entry front_entry;
    t_q_entry head_entry;
    logic     push;
    logic     pop;
    logic     q_full;
    logic     q_valid;

    u8sd_front u_front (
        .i_in_valid  (i_in_valid),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_q_full    (q_full),
        .o_in_stall  (o_in_stall),
        .o_push      (push),
        .o_entry     (front_entry)
    );

    u8sd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (head_entry)
    );

    u8sd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_entry         (head_entry),
        .o_pop           (pop),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_code_point    (o_code_point),
        .o_kind          (o_kind),
        .o_end_of_string (o_end_of_string)
    );

endmodule

/* bench/tb.sv */
// Self-checking bench for the UTF-8 stream decoder: directed table, random strings, stalls.
`timescale 1ns / 100ps

module tb;
    import u8sd_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int LONG_HOLD   = 300;

    // How a queued request is checked
    typedef enum logic [1:0] {
        CHK_PRED = 2'd0,   // expectation from the decoder model below
        CHK_NONE = 2'd1,   // typed: no result
        CHK_RES  = 2'd2    // typed: result given in the row
    } t_chk;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic [1:0]      kind;
        logic            eos;
    } t_result;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        t_chk       chk;
        t_result    res;
    } t_req;

    localparam t_result NO_RES = '0;

    // Directed requests: plain ASCII, each sequence length, max values, every fault path
    localparam t_req DIR_TAB [25] = '{
        '{8'h41, 1'b0, CHK_RES,  '{21'h41, KIND_CODE, 1'b0}},
        '{8'h00, 1'b0, CHK_RES,  '{21'h00, KIND_CODE, 1'b0}},
        '{8'h7F, 1'b0, CHK_RES,  '{21'h7F, KIND_CODE, 1'b0}},
        '{8'hC3, 1'b0, CHK_PRED, NO_RES},
        '{8'hA9, 1'b0, CHK_PRED, NO_RES},
        '{8'hE2, 1'b0, CHK_PRED, NO_RES},
        '{8'h82, 1'b0, CHK_PRED, NO_RES},
        '{8'hAC, 1'b0, CHK_PRED, NO_RES},
        '{8'hF7, 1'b0, CHK_PRED, NO_RES},
        '{8'hBF, 1'b0, CHK_PRED, NO_RES},
        '{8'hBF, 1'b0, CHK_PRED, NO_RES},
        '{8'hBF, 1'b0, CHK_PRED, NO_RES},
        '{8'h80, 1'b0, CHK_RES,  '{21'h0, KIND_ERROR, 1'b0}},
        '{8'h41, 1'b0, CHK_NONE, NO_RES},
        '{8'hFF, 1'b1, CHK_RES,  '{21'h0, KIND_END, 1'b1}},
        '{8'hFF, 1'b1, CHK_RES,  '{21'h0, KIND_ERROR, 1'b1}},
        '{8'hC3, 1'b1, CHK_RES,  '{21'h0, KIND_ERROR, 1'b1}},
        '{8'hE2, 1'b0, CHK_PRED, NO_RES},
        '{8'h41, 1'b0, CHK_RES,  '{21'h0, KIND_ERROR, 1'b0}},
        '{8'h00, 1'b1, CHK_RES,  '{21'h0, KIND_END, 1'b1}},
        '{8'hE2, 1'b0, CHK_PRED, NO_RES},
        '{8'h82, 1'b1, CHK_RES,  '{21'h0, KIND_ERROR, 1'b1}},
        '{8'hF8, 1'b0, CHK_RES,  '{21'h0, KIND_ERROR, 1'b0}},
        '{8'h00, 1'b1, CHK_RES,  '{21'h0, KIND_END, 1'b1}},
        '{8'h7F, 1'b1, CHK_RES,  '{21'h7F, KIND_CODE, 1'b1}}
    };

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_in_valid = 1'b0;
    logic            o_in_stall;
    logic [7:0]      i_data_byte = 8'h00;
    logic            i_last_byte = 1'b0;
    logic            o_out_valid;
    logic            i_out_stall = 1'b0;
    logic [CP_W-1:0] o_code_point;
    logic [1:0]      o_kind;
    logic            o_end_of_string;

    utf8_stream_decoder_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_code_point    (o_code_point),
        .o_kind          (o_kind),
        .o_end_of_string (o_end_of_string)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_req    pending_bytes[$];
    t_result expected_results[$];

    // decoder model state, at its reset values
    logic [1:0]      dec_pending = 2'd0;
    logic [CP_W-1:0] dec_bits    = '0;
    logic            dec_discard = 1'b0;

    bit idle_on = 1'b0;
    bit sending = 1'b0;
    int hold_asks = 0;
    int n_queued = 0;
    int n_taken = 0;
    int n_fail = 0;
    int n_codes = 0;
    int n_errors = 0;
    int n_ends = 0;
    int cyc = 0;

    // Decode one byte: advances the model state, says whether a result comes and what it is
    task automatic decode_byte(input logic [7:0] b, input logic lst,
                               output logic has, output t_result r);
        logic fault;
        fault = 1'b0;
        has = 1'b0;
        r = '0;
        r.kind = KIND_CODE;
        r.eos = lst;
        if (dec_discard) begin
            if (lst) begin
                has = 1'b1;
                r.kind = KIND_END;
            end
        end else if (dec_pending == 2'd0) begin
            casez (b)
                8'b0???????: begin
                    has = 1'b1;
                    r.cp = CP_W'(b);
                end
                8'b110?????: begin
                    dec_pending = 2'd1;
                    dec_bits = CP_W'(b[4:0]);
                end
                8'b1110????: begin
                    dec_pending = 2'd2;
                    dec_bits = CP_W'(b[3:0]);
                end
                8'b11110???: begin
                    dec_pending = 2'd3;
                    dec_bits = CP_W'(b[2:0]);
                end
                default: fault = 1'b1;
            endcase
            // lead of a multi-byte form on the last byte: string ends mid-sequence
            if (!fault && dec_pending != 2'd0 && lst) fault = 1'b1;
        end else if (b[7:6] != 2'b10) begin
            fault = 1'b1;
        end else begin
            dec_bits = {dec_bits[CP_W-7:0], b[5:0]};
            dec_pending = dec_pending - 2'd1;
            if (dec_pending == 2'd0) begin
                has = 1'b1;
                r.cp = dec_bits;
                dec_bits = '0;
            end else if (lst) begin
                fault = 1'b1;
            end
        end
        if (fault) begin
            has = 1'b1;
            r.kind = KIND_ERROR;
            r.cp = '0;
            dec_pending = 2'd0;
            dec_bits = '0;
            dec_discard = !lst;
        end
        if (lst) begin
            dec_pending = 2'd0;
            dec_bits = '0;
            dec_discard = 1'b0;
        end
    endtask

    // One random string: mostly well formed, some corrupted, truncated or pure noise
    task automatic queue_string();
        logic [7:0]  s[$];
        logic [31:0] rnd;
        int nchar, len, pos, mode;
        t_req q;
        nchar = $urandom_range(1, 8);
        for (int c = 0; c < nchar; c++) begin
            len = $urandom_range(1, 4);
            rnd = $urandom;
            case (len)
                1: s.push_back({1'b0, rnd[6:0]});
                2: s.push_back({3'b110, rnd[4:0]});
                3: s.push_back({4'b1110, rnd[3:0]});
                default: s.push_back({5'b11110, rnd[2:0]});
            endcase
            for (int k = 1; k < len; k++) begin
                rnd = $urandom;
                s.push_back({2'b10, rnd[5:0]});
            end
        end
        mode = $urandom_range(0, 9);
        pos = $urandom_range(0, s.size() - 1);
        rnd = $urandom;
        case (mode)
            6: s[pos] = rnd[7:0];
            7: while (s.size() > pos + 1) void'(s.pop_back());
            8: s.insert(pos, rnd[7:0]);
            9: begin
                len = $urandom_range(1, 6);
                s.delete();
                for (int k = 0; k < len; k++) begin
                    rnd = $urandom;
                    s.push_back(rnd[7:0]);
                end
            end
            default: ;
        endcase
        foreach (s[i]) begin
            q.data = s[i];
            q.last = (i == s.size() - 1);
            q.chk = CHK_PRED;
            q.res = NO_RES;
            pending_bytes.push_back(q);
            n_queued++;
        end
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || sending || expected_results.size() != 0)
            @(negedge i_clk);
    endtask

    // Sender: offers queued requests, random gaps after some accepted ones while idling is on
    t_req cur_req;
    int   send_gap = 0;

    always @(posedge i_clk) begin
        logic    nv;
        logic    has;
        t_result r;
        nv = i_in_valid;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                decode_byte(cur_req.data, cur_req.last, has, r);
                case (cur_req.chk)
                    CHK_PRED: if (has) expected_results.push_back(r);
                    CHK_RES:  expected_results.push_back(cur_req.res);
                    default:  ;
                endcase
                n_taken++;
                nv = 1'b0;
                if (idle_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 10);
            end
            if (!nv) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_bytes.size() > 0) begin
                    cur_req = pending_bytes.pop_front();
                    nv = 1'b1;
                    i_data_byte <= cur_req.data;
                    i_last_byte <= cur_req.last;
                end
            end
        end
        sending = nv;
        i_in_valid <= nv;
    end

    // Receiver: checks each accepted result, stalls in bursts or for a long hold
    int stall_left = 0;
    int hold_left = 0;
    int hold_done = 0;

    always @(posedge i_clk) begin
        logic    ns;
        t_result e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            case (o_kind)
                KIND_CODE:  n_codes++;
                KIND_ERROR: n_errors++;
                default:    n_ends++;
            endcase
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, cp %h kind %0d eos %0d",
                         $time, o_code_point, o_kind, o_end_of_string);
                n_fail++;
            end else begin
                e = expected_results.pop_front();
                if (o_kind !== e.kind) begin
                    $display("%0t: kind mismatch, expected %0d, actual %0d",
                             $time, e.kind, o_kind);
                    n_fail++;
                end
                if (o_code_point !== e.cp) begin
                    $display("%0t: code point mismatch, expected %h, actual %h",
                             $time, e.cp, o_code_point);
                    n_fail++;
                end
                if (o_end_of_string !== e.eos) begin
                    $display("%0t: end flag mismatch, expected %0d, actual %0d",
                             $time, e.eos, o_end_of_string);
                    n_fail++;
                end
            end
        end
        ns = 1'b0;
        if (hold_asks != hold_done) begin
            hold_done++;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            ns = 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            ns = 1'b1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 10) - 1;
            ns = 1'b1;
        end
        i_out_stall <= ns;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cyc++;
        if (cyc > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still outstanding", $time,
                     expected_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Phases
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        idle_on = 1'b1;

        // directed table
        foreach (DIR_TAB[i]) pending_bytes.push_back(DIR_TAB[i]);
        wait_drained();

        // random strings with idling on both sides
        while (n_queued < 750) queue_string();
        wait_drained();

        // long receiver hold while the sender keeps offering
        hold_asks++;
        repeat (15) queue_string();
        wait_drained();

        while (n_queued < 1550) queue_string();
        wait_drained();

        // back to back, no idling
        idle_on = 1'b0;
        while (n_queued < 1850) queue_string();
        wait_drained();
        repeat (20) @(negedge i_clk);

        $display("decoded %0d bytes in %0d cycles: %0d code points, %0d errors, %0d end markers",
                 n_taken, cyc, n_codes, n_errors, n_ends);
        if (n_fail == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
